### rtl/core/tbp_pkg.sv
// Shared types and constants for the tournament branch predictor.
// No dependencies.
package tbp_pkg;

   localparam int unsigned COUNT_WIDTH = 32;

   localparam logic [1:0] CTR_MIN       = 2'd0;
   localparam logic [1:0] CTR_MAX       = 2'd3;
   localparam logic [1:0] CHOOSER_RESET = 2'd0;
   localparam logic [1:0] PHT_RESET     = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

   typedef struct packed {
      logic                   pred;
      logic                   use_bim;
      logic                   ok;
      logic [1:0]             chooser;
      logic [1:0]             bimodal;
      logic [1:0]             gshare;
      logic [COUNT_WIDTH-1:0] hit_count;
   } upd_type;

endpackage

### rtl/core/tbp_ram.sv
// Single-port-write, single-port-read synchronous RAM, registered read data.
// No dependencies.
module tbp_ram #(
   parameter int unsigned ADDR_BITS = 11,
   parameter int unsigned DATA_BITS = 2
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/tbp_update.sv
// Prediction select, chooser and counter training, saturating hit count.
// Depends on tbp_pkg.
module tbp_update (
   input  logic [1:0]                      chooser_ctr,
   input  logic [1:0]                      bimodal_ctr,
   input  logic [1:0]                      gshare_ctr,
   input  logic                            taken,
   input  logic [tbp_pkg::COUNT_WIDTH-1:0] hit_count,
   output tbp_pkg::upd_type                upd
);

   function automatic logic [1:0] train2(input logic [1:0] ctr, input logic up);
      logic [1:0] res;
      res = ctr;
      if (up) begin
         if (ctr != tbp_pkg::CTR_MAX) res = ctr + 2'd1;
      end else begin
         if (ctr != tbp_pkg::CTR_MIN) res = ctr - 2'd1;
      end
      return res;
   endfunction

   logic g_pred;
   logic b_pred;
   logic g_ok;
   logic b_ok;

   always_comb begin
      g_pred       = gshare_ctr[1];
      b_pred       = bimodal_ctr[1];
      g_ok         = (g_pred == taken);
      b_ok         = (b_pred == taken);
      upd.use_bim  = chooser_ctr[1];
      upd.pred     = upd.use_bim ? b_pred : g_pred;
      upd.ok       = (upd.pred == taken);
      upd.chooser  = (g_ok != b_ok) ? train2(chooser_ctr, b_ok) : chooser_ctr;
      upd.bimodal  = train2(bimodal_ctr, taken);
      upd.gshare   = train2(gshare_ctr, taken);
      upd.hit_count = hit_count;
      if (upd.ok && (hit_count != '1)) begin
         upd.hit_count = hit_count + tbp_pkg::COUNT_WIDTH'(1);
      end
   end

endmodule

### rtl/core/tournament_branch_predictor.sv
// Tournament branch predictor: gshare + bimodal with per-address chooser.
// Counters are read into registered RAM outputs on acceptance; the response registers load on
// commit in lookup, which waits while an unaccepted response is held. One branch at a time:
// no new request until write-back (counter memory read, then write-back).
// Reset: history, hit count clear; then the 2**INDEX_BITS (2048) table entries load, req_ready low.
module tournament_branch_predictor #(
   parameter int unsigned INDEX_BITS   = 11,
   parameter int unsigned HISTORY_BITS = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_branch_address,
   input  logic        req_taken,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_predicted_taken,
   output logic        rsp_used_bimodal,
   output logic        rsp_correct,
   output logic [31:0] rsp_correct_total
);

   tbp_pkg::state_type state_ff, state_in;

   logic [INDEX_BITS-1:0]           clr_idx_ff, clr_idx_in;
   logic [HISTORY_BITS-1:0]         history_ff, history_in;
   logic [tbp_pkg::COUNT_WIDTH-1:0] hit_ff, hit_in;
   logic [INDEX_BITS-1:0]           bidx_ff, gidx_ff;
   logic                            taken_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_pred_ff, rsp_bim_ff, rsp_ok_ff;
   logic [31:0]                     rsp_total_ff;

   logic [INDEX_BITS-1:0] hist_idx;
   logic [INDEX_BITS-1:0] req_bidx, req_gidx;
   logic                  accept;
   logic                  commit;
   logic                  rd_en;
   logic                  wr_en;
   logic [INDEX_BITS-1:0] wr_bidx, wr_gidx;
   logic [3:0]            cb_wr_data, cb_rd_data;
   logic [1:0]            gs_wr_data, gs_rd_data;
   tbp_pkg::upd_type      upd;

   generate
      if (HISTORY_BITS >= INDEX_BITS) begin : g_hist_trunc
         assign hist_idx = history_ff[INDEX_BITS-1:0];
      end else begin : g_hist_ext
         assign hist_idx = {{(INDEX_BITS-HISTORY_BITS){1'b0}}, history_ff};
      end
   endgenerate

   assign req_bidx  = req_branch_address[INDEX_BITS-1:0];
   assign req_gidx  = req_bidx ^ hist_idx;
   assign req_ready = (state_ff == tbp_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rd_en     = accept;
   assign commit    = (state_ff == tbp_pkg::ST_LOOKUP) && (!rsp_valid_ff || rsp_ready);

   // chooser in the upper two bits, bimodal in the lower two
   tbp_ram #(.ADDR_BITS(INDEX_BITS), .DATA_BITS(4)) u_cb_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (req_bidx),
      .rd_data (cb_rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_bidx),
      .wr_data (cb_wr_data)
   );

   tbp_ram #(.ADDR_BITS(INDEX_BITS), .DATA_BITS(2)) u_gs_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (req_gidx),
      .rd_data (gs_rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_gidx),
      .wr_data (gs_wr_data)
   );

   tbp_update u_update (
      .chooser_ctr (cb_rd_data[3:2]),
      .bimodal_ctr (cb_rd_data[1:0]),
      .gshare_ctr  (gs_rd_data),
      .taken       (taken_ff),
      .hit_count   (hit_ff),
      .upd         (upd)
   );

   always_comb begin
      wr_en      = 1'b0;
      wr_bidx    = bidx_ff;
      wr_gidx    = gidx_ff;
      cb_wr_data = {upd.chooser, upd.bimodal};
      gs_wr_data = upd.gshare;
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      history_in = history_ff;
      hit_in     = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         tbp_pkg::ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_bidx    = clr_idx_ff;
            wr_gidx    = clr_idx_ff;
            cb_wr_data = {tbp_pkg::CHOOSER_RESET, tbp_pkg::PHT_RESET};
            gs_wr_data = tbp_pkg::PHT_RESET;
            clr_idx_in = clr_idx_ff + INDEX_BITS'(1);
            if (clr_idx_ff == '1) begin
               state_in = tbp_pkg::ST_IDLE;
            end
         end
         tbp_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = tbp_pkg::ST_LOOKUP;
            end
         end
         tbp_pkg::ST_LOOKUP: begin
            if (commit) begin
               wr_en        = 1'b1;
               history_in   = (history_ff << 1) | HISTORY_BITS'(taken_ff);
               hit_in       = upd.hit_count;
               rsp_valid_in = 1'b1;
               state_in     = tbp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tbp_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbp_pkg::ST_CLEAR;
         clr_idx_ff   <= '0;
         history_ff   <= '0;
         hit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         history_ff   <= history_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bidx_ff  <= req_bidx;
         gidx_ff  <= req_gidx;
         taken_ff <= req_taken;
      end
      if (commit) begin
         rsp_pred_ff  <= upd.pred;
         rsp_bim_ff   <= upd.use_bim;
         rsp_ok_ff    <= upd.ok;
         rsp_total_ff <= upd.hit_count;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_taken = rsp_pred_ff;
   assign rsp_used_bimodal    = rsp_bim_ff;
   assign rsp_correct         = rsp_ok_ff;
   assign rsp_correct_total   = rsp_total_ff;

   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == tbp_pkg::ST_LOOKUP))
      else $error("accepted transaction did not enter lookup");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tbp_pkg::ST_IDLE) |-> !wr_en)
      else $error("table write while idle");

   a_commit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> (rsp_valid_ff && (rsp_correct_total == hit_ff)))
      else $error("response not loaded with running count");

   a_hit_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff != tbp_pkg::ST_CLEAR) |=> (hit_ff >= $past(hit_ff)))
      else $error("hit count decreased");

   a_no_ready_in_lookup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tbp_pkg::ST_LOOKUP) |-> !req_ready)
      else $error("request ready during lookup");

endmodule

### tb/testbench.sv
// Self-checking testbench for tournament_branch_predictor (gshare + bimodal).
// Holds its own model of the counter tables and history; needs tbp_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned TABLE_DEPTH    = 2048;
   localparam int unsigned BRANCH_COUNT   = 1850;
   localparam int unsigned POOL_SIZE      = 12;
   localparam int unsigned WATCHDOG_LIMIT = 12000;
   localparam int unsigned HOLD_CYCLES    = 80;
   localparam int unsigned HOLD_AT        = 300;
   localparam int unsigned QUIET_TAIL     = 200;

   localparam int unsigned MODE_TAKEN     = 0;
   localparam int unsigned MODE_NOT_TAKEN = 1;
   localparam int unsigned MODE_ALTERNATE = 2;
   localparam int unsigned MODE_RANDOM    = 3;

   typedef struct packed {
      logic [31:0] address;
      logic        taken;
   } branch_type;

   typedef struct packed {
      logic        predicted_taken;
      logic        used_bimodal;
      logic        correct;
      logic [31:0] correct_total;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_branch_address = '0;
   logic        req_taken = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_predicted_taken;
   logic        rsp_used_bimodal;
   logic        rsp_correct;
   logic [31:0] rsp_correct_total;

   branch_type  pending_branches[$];
   outcome_type expected_outcomes[$];

   logic [1:0]  chooser_tbl [TABLE_DEPTH];
   logic [1:0]  gshare_tbl  [TABLE_DEPTH];
   logic [1:0]  bimodal_tbl [TABLE_DEPTH];
   logic [10:0] history;
   logic [31:0] hit_total;

   int unsigned accepted_count = 0;
   int unsigned resolved_count = 0;
   int unsigned errors = 0;
   int unsigned send_gap = 0;
   int unsigned stall_gap = 0;
   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;
   int unsigned quiet_cycles = 0;

   tournament_branch_predictor u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_branch_address  (req_branch_address),
      .req_taken           (req_taken),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_predicted_taken (rsp_predicted_taken),
      .rsp_used_bimodal    (rsp_used_bimodal),
      .rsp_correct         (rsp_correct),
      .rsp_correct_total   (rsp_correct_total)
   );

   always #5 clock = ~clock;

   function automatic logic [1:0] train_ctr(logic [1:0] ctr, logic up);
      if (up) return (ctr == tbp_pkg::CTR_MAX) ? tbp_pkg::CTR_MAX : ctr + 2'd1;
      return (ctr == tbp_pkg::CTR_MIN) ? tbp_pkg::CTR_MIN : ctr - 2'd1;
   endfunction

   // idling in windows, with a quiet stretch every third window and none at the tail
   function automatic logic idle_allowed();
      return (accepted_count + QUIET_TAIL < BRANCH_COUNT) && ((accepted_count / 150) % 3 != 2);
   endfunction

   task automatic append_branch(input logic [31:0] address, input logic taken);
      branch_type b;
      b.address = address;
      b.taken   = taken;
      pending_branches.insert(pending_branches.size(), b);
   endtask

   task automatic predict_branch(input logic [31:0] address, input logic taken);
      logic [10:0] bidx;
      logic [10:0] gidx;
      logic        g_pred;
      logic        b_pred;
      logic        use_bim;
      logic        pred;
      outcome_type res;
      bidx    = address[10:0];
      gidx    = address[10:0] ^ history;
      g_pred  = gshare_tbl[gidx][1];
      b_pred  = bimodal_tbl[bidx][1];
      use_bim = chooser_tbl[bidx][1];
      pred    = use_bim ? b_pred : g_pred;
      if (pred == taken && hit_total != '1) hit_total = hit_total + 32'd1;
      if ((g_pred == taken) != (b_pred == taken))
         chooser_tbl[bidx] = train_ctr(chooser_tbl[bidx], b_pred == taken);
      gshare_tbl[gidx]  = train_ctr(gshare_tbl[gidx], taken);
      bimodal_tbl[bidx] = train_ctr(bimodal_tbl[bidx], taken);
      history = {history[9:0], taken};
      res.predicted_taken = pred;
      res.used_bimodal    = use_bim;
      res.correct         = (pred == taken);
      res.correct_total   = hit_total;
      expected_outcomes.insert(expected_outcomes.size(), res);
   endtask

   task automatic report_field(input string name, input logic [31:0] exp, input logic [31:0] act);
      if (act !== exp) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp, act);
         errors++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      branch_type next;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_branch(req_branch_address, req_taken);
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
               send_gap  <= $urandom_range(0, 4);
               req_valid <= 1'b0;
            end else if (pending_branches.size() != 0) begin
               next = pending_branches.pop_front();
               req_branch_address <= next.address;
               req_taken          <= next.taken;
               req_valid          <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      outcome_type exp;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_gap <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            resolved_count++;
            if (expected_outcomes.size() == 0) begin
               $display("%0t: result with no pending branch: expected none, actual %0h",
                        $time, {rsp_predicted_taken, rsp_used_bimodal, rsp_correct,
                                rsp_correct_total});
               errors++;
            end else begin
               exp = expected_outcomes.pop_front();
               report_field("predicted_taken", 32'(exp.predicted_taken),
                            32'(rsp_predicted_taken));
               report_field("used_bimodal", 32'(exp.used_bimodal), 32'(rsp_used_bimodal));
               report_field("correct", 32'(exp.correct), 32'(rsp_correct));
               report_field("correct_total", exp.correct_total, rsp_correct_total);
            end
         end
         // one long hold-off so the block backs up into its input
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (!hold_done && resolved_count >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (stall_gap != 0) begin
            stall_gap <= stall_gap - 1;
            rsp_ready <= 1'b0;
         end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
            stall_gap <= $urandom_range(0, 4);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [31:0] pool [POOL_SIZE];
      int unsigned mode [POOL_SIZE];
      logic        phase [POOL_SIZE];
      int unsigned k;
      int unsigned run;
      logic        tk;

      for (int i = 0; i < TABLE_DEPTH; i++) begin
         chooser_tbl[i] = tbp_pkg::CHOOSER_RESET;
         gshare_tbl[i]  = tbp_pkg::PHT_RESET;
         bimodal_tbl[i] = tbp_pkg::PHT_RESET;
      end
      history   = '0;
      hit_total = '0;

      // directed: address extremes, counters driven to both limits, aliasing, alternation
      append_branch(32'h0000_0000, 1'b1);
      repeat (4) append_branch(32'h0000_0000, 1'b0);
      append_branch(32'hFFFF_FFFF, 1'b1);
      repeat (4) append_branch(32'hFFFF_FFFF, 1'b0);
      append_branch(32'h0000_07FF, 1'b0);
      append_branch(32'hFFFF_F800, 1'b1);
      append_branch(32'hAAAA_AAAA, 1'b1);
      append_branch(32'h5555_5555, 1'b0);
      for (int i = 0; i < 8; i++) append_branch(32'h0000_0100, i[0] == 1'b0);

      // random: mostly recurring branches with a per-branch behavior, some noise
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool[i] = $urandom;
         if (i > 0 && $urandom_range(0, 3) == 0)
            pool[i] = ($urandom & 32'hFFFF_F800) | (pool[i-1] & 32'h0000_07FF);
         mode[i]  = $urandom_range(MODE_TAKEN, MODE_RANDOM);
         phase[i] = 1'b0;
      end
      while (pending_branches.size() < BRANCH_COUNT) begin
         if ($urandom_range(0, 4) == 0) begin
            append_branch($urandom, 1'($urandom_range(0, 1)));
         end else begin
            k   = $urandom_range(0, POOL_SIZE - 1);
            run = $urandom_range(1, 8);
            for (int r = 0; r < run; r++) begin
               case (mode[k])
                  MODE_TAKEN: tk = ($urandom_range(0, 15) != 0);
                  MODE_NOT_TAKEN: tk = ($urandom_range(0, 15) == 0);
                  MODE_ALTERNATE: begin
                     tk       = phase[k];
                     phase[k] = ~phase[k];
                  end
                  default: tk = 1'($urandom_range(0, 1));
               endcase
               append_branch(pool[k], tk);
            end
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < BRANCH_COUNT) @(posedge clock);
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/tbp_pkg.sv
rtl/core/tbp_ram.sv
rtl/core/tbp_update.sv
rtl/core/tournament_branch_predictor.sv
tb/testbench.sv
